// File: src/lzsd_pkg.sv
package lzsd_pkg;

   // Default history depth in bytes.
   localparam int WINDOW_DEPTH_DEF = 128;

   // Width of the copy length count: a reference yields at most 17 bytes.
   localparam int CNT_W = 5;

   // Split shift after reset.
   localparam logic [2:0] SPLIT_RESET = 3'd4;

   // Parser and output sequencer states.
   typedef enum logic [2:0] {
      ST_HDR_HI,
      ST_HDR_LO,
      ST_FLAGS,
      ST_TOKEN,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic hdr_hi;     // header high byte accepted
      logic hdr_lo;     // header low byte accepted
      logic flags;      // flag byte accepted
      logic token;      // literal or reference byte accepted
      logic out_write;  // output byte taken: store it in the history
      logic advance;    // more bytes of this copy follow: fetch the next one
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic tokens_zero;  // no tokens left in this group after the current one
      logic groups_zero;  // no groups left after the current one
      logic last_byte;    // the byte on the output is the last of its token
   } status_type;

endpackage

// File: src/lzsd_ctrl.sv
module lzsd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  lzsd_pkg::status_type status,
   output lzsd_pkg::cmd_type    cmd
);
   import lzsd_pkg::*;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic      in_fire;
   logic      out_fire;

   // Handshake qualifiers.
   assign in_fire  = req_tvalid && req_tready;
   assign out_fire = rsp_tvalid && rsp_tready;

   // Next state; ret holds where parsing resumes once a token's bytes are out.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         ST_HDR_HI: begin
            if (in_fire) state_in = ST_HDR_LO;
         end
         ST_HDR_LO: begin
            if (in_fire) state_in = ST_FLAGS;
         end
         ST_FLAGS: begin
            if (in_fire) state_in = ST_TOKEN;
         end
         ST_TOKEN: begin
            if (in_fire) begin
               state_in = ST_EMIT;
               priority if (!status.tokens_zero) begin
                  ret_in = ST_TOKEN;
               end else if (!status.groups_zero) begin
                  ret_in = ST_FLAGS;
               end else begin
                  ret_in = ST_HDR_HI;
               end
            end
         end
         ST_EMIT: begin
            if (out_fire && status.last_byte) state_in = ret_ff;
         end
         default: state_in = ST_HDR_HI;
      endcase
   end

   // Handshakes and datapath commands.
   always_comb begin
      req_tready    = (state_ff != ST_EMIT);
      rsp_tvalid    = (state_ff == ST_EMIT);
      cmd.hdr_hi    = in_fire && (state_ff == ST_HDR_HI);
      cmd.hdr_lo    = in_fire && (state_ff == ST_HDR_LO);
      cmd.flags     = in_fire && (state_ff == ST_FLAGS);
      cmd.token     = in_fire && (state_ff == ST_TOKEN);
      cmd.out_write = out_fire;
      cmd.advance   = out_fire && !status.last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HDR_HI;
         ret_ff   <= ST_HDR_HI;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

// File: src/lzsd_datapath.sv
module lzsd_datapath #(
   parameter int WINDOW_DEPTH = lzsd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           in_byte,
   input  lzsd_pkg::cmd_type    cmd,
   output lzsd_pkg::status_type status,
   output logic [7:0]           out_byte,
   output logic                 last_of_run,
   output logic                 end_of_stream
);
   import lzsd_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam logic [AW:0]   DEPTH_X = (AW+1)'(WINDOW_DEPTH);
   localparam logic [AW-1:0] LAST_PTR = AW'(WINDOW_DEPTH - 1);

   // Stream parsing state.
   logic [2:0]       split_ff, split_in;
   logic [13:0]      groups_ff, groups_in;
   logic [7:0]       flags_ff, flags_in;
   logic [2:0]       tokens_ff, tokens_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             eos_ff, eos_in;

   // History ring and its pointers.
   logic [7:0]       hist_ff [WINDOW_DEPTH];
   logic [AW-1:0]    wp_ff, wp_in;
   logic             wrapped_ff, wrapped_in;
   logic [AW-1:0]    rd_ff, rd_in;

   // Output byte sources.
   logic [7:0]       mem_q_ff;
   logic [7:0]       byp_data_ff;
   logic             byp_ff;
   logic             zero_ff;

   logic [7:0]       mask;
   logic [7:0]       distance;
   logic [CNT_W-1:0] len;
   logic [AW:0]      wp_x;
   logic [AW:0]      dist_x;
   logic [AW-1:0]    start;
   logic [AW-1:0]    ra;
   logic             rd_en;
   logic             load_lit;
   logic             bypass;
   logic             slot_written;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   // Split the reference byte into length and distance.
   always_comb begin
      unique case (split_ff)
         3'd1: begin
            mask     = 8'h01;
            distance = (in_byte >> 1) + 8'd1;
         end
         3'd2: begin
            mask     = 8'h03;
            distance = (in_byte >> 2) + 8'd1;
         end
         3'd3: begin
            mask     = 8'h07;
            distance = (in_byte >> 3) + 8'd1;
         end
         default: begin
            mask     = 8'h0F;
            distance = (in_byte >> 4) + 8'd1;
         end
      endcase
      len = CNT_W'(in_byte & mask) + CNT_W'(2);
   end

   // First copy address: write pointer minus distance, around the ring.
   always_comb begin
      wp_x   = {1'b0, wp_ff};
      dist_x = (AW+1)'(distance);
      if (wp_x >= dist_x) begin
         start = AW'(wp_x - dist_x);
      end else begin
         start = AW'(wp_x + DEPTH_X - dist_x);
      end
   end

   // History read control; a read of the slot being written takes the new byte.
   always_comb begin
      load_lit     = cmd.token && !flags_ff[7];
      rd_en        = (cmd.token && flags_ff[7]) || cmd.advance;
      ra           = cmd.advance ? rd_ff : start;
      bypass       = cmd.out_write && (ra == wp_ff);
      slot_written = wrapped_ff || (ra < wp_ff);
   end

   // Next values of the parsing state and pointers.
   always_comb begin
      split_in   = split_ff;
      groups_in  = groups_ff;
      flags_in   = flags_ff;
      tokens_in  = tokens_ff;
      cnt_in     = cnt_ff;
      eos_in     = eos_ff;
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      rd_in      = rd_ff;
      if (cmd.hdr_hi) begin
         split_in  = SPLIT_RESET - {1'b0, in_byte[7:6]};
         groups_in = {in_byte[5:0], 8'h00};
      end
      if (cmd.hdr_lo) begin
         groups_in = {groups_ff[13:8], in_byte};
      end
      if (cmd.flags) begin
         flags_in  = in_byte;
         tokens_in = 3'd7;
      end
      if (cmd.token) begin
         flags_in = {flags_ff[6:0], 1'b0};
         cnt_in   = flags_ff[7] ? len : CNT_W'(1);
         eos_in   = (tokens_ff == 3'd0) && (groups_ff == 14'd0);
         rd_in    = ptr_inc(start);
         if (tokens_ff != 3'd0) begin
            tokens_in = tokens_ff - 3'd1;
         end else if (groups_ff != 14'd0) begin
            groups_in = groups_ff - 14'd1;
         end
      end
      if (cmd.out_write) begin
         cnt_in = cnt_ff - CNT_W'(1);
         wp_in  = ptr_inc(wp_ff);
         if (wp_ff == LAST_PTR) wrapped_in = 1'b1;
      end
      if (cmd.advance) begin
         rd_in = ptr_inc(rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff   <= SPLIT_RESET;
         groups_ff  <= '0;
         flags_ff   <= '0;
         tokens_ff  <= '0;
         cnt_ff     <= '0;
         eos_ff     <= 1'b0;
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         rd_ff      <= '0;
      end else begin
         split_ff   <= split_in;
         groups_ff  <= groups_in;
         flags_ff   <= flags_in;
         tokens_ff  <= tokens_in;
         cnt_ff     <= cnt_in;
         eos_ff     <= eos_in;
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
         rd_ff      <= rd_in;
      end
   end

   // History memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.out_write) hist_ff[wp_ff] <= out_byte;
      if (rd_en) mem_q_ff <= hist_ff[ra];
   end

   // Source select for the output byte, held while the receiver stalls.
   always_ff @(posedge clock) begin
      if (load_lit) begin
         byp_ff      <= 1'b1;
         byp_data_ff <= in_byte;
         zero_ff     <= 1'b0;
      end else if (rd_en) begin
         byp_ff      <= bypass;
         byp_data_ff <= out_byte;
         zero_ff     <= !bypass && !slot_written;
      end
   end

   // Result outputs and controller status.
   always_comb begin
      priority if (byp_ff) begin
         out_byte = byp_data_ff;
      end else if (zero_ff) begin
         out_byte = 8'h00;
      end else begin
         out_byte = mem_q_ff;
      end
      last_of_run        = (cnt_ff == CNT_W'(1));
      end_of_stream      = eos_ff && last_of_run;
      status.tokens_zero = (tokens_ff == 3'd0);
      status.groups_zero = (groups_ff == 14'd0);
      status.last_byte   = last_of_run;
   end

endmodule

// File: src/lzss_split_byte_decoder.sv
// LZSS decoder with 8-bit flag groups and a header-selected length/distance split.
// Input channel req_*: one compressed byte per transaction. A stream is a 16-bit
// big-endian header, then groups of one flag byte and eight tokens.
// Result channel rsp_*: one decompressed byte per transaction; rsp_tlast marks the
// last byte caused by one input byte, rsp_tuser the last byte of the whole stream.
// Header and flag bytes yield nothing.
// A literal yields its byte in the cycle after acceptance; a reference yields
// 2 to 17 bytes, the first in the cycle after acceptance, then one per cycle
// while the receiver is ready: the single read and write port of the history
// memory carries one byte a cycle.
// req_tready is low while result bytes are pending; a stalled receiver holds the
// current result byte steady and freezes the copy.
// Reset returns the parser to the header, sets the split shift to 4 and the write
// pointer to 0. History slots never written read as zero, tracked by the write
// pointer and a wrap flag, so no clearing pass is needed.
module lzss_split_byte_decoder #(
   parameter int WINDOW_DEPTH = lzsd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // last_of_run
   output logic       rsp_tuser    // [0] end_of_stream
);
   import lzsd_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Parser and output sequencer.
   lzsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Parsing registers, history memory and output byte.
   lzsd_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .in_byte       (req_tdata),
      .cmd           (cmd),
      .status        (status),
      .out_byte      (rsp_tdata),
      .last_of_run   (rsp_tlast),
      .end_of_stream (rsp_tuser)
   );

endmodule

// File: src/lzsd_checker.sv
module lzsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // A stalled result byte and its flags hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result transaction changed");

   // No new input byte is taken while result bytes are pending.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while results pending");

   // The end of a stream is always the end of a token's run.
   a_eos_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end of stream without end of run");

   // A copy continues in the very next cycle after a byte that is not last.
   a_copy_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("copy run broke off early");

   // No result is offered in the first cycle after reset is released.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind lzss_split_byte_decoder lzsd_checker u_lzsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
